FILE: rtl/core/pp2r_pkg.sv
`default_nettype none
package pp2r_pkg;

   // number of pixel lanes: one per pixel of a word at the narrowest depth
   localparam int LANES   = 32;
   localparam int LANE_W  = 5;
   // width of an unclamped pixel column: word column times 32 plus lane
   localparam int XW      = 15;

   localparam int WORD_W  = 32;
   localparam int COL_W   = 10;
   localparam int COLOR_W = 16;
   localparam int PX_W    = 11;
   localparam int LEFT_W  = 11;
   localparam int RIGHT_W = 12;
   localparam int DEPTH_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // pixel depth codes
   localparam logic [DEPTH_W-1:0] DEPTH_1BIT  = 2'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_8BIT  = 2'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_16BIT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEFT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RIGHT = 2'd2;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;

   typedef struct packed {
      logic               hit;
      logic [COLOR_W-1:0] color;
      logic [PX_W-1:0]    x;
      logic               line_end;
   } lane_out_type;

   // 3-3-2 index to 5-6-5: components land in the top bits of each field
   function automatic logic [COLOR_W-1:0] color_8(input logic [7:0] v);
      color_8 = {v[7:5], 2'b00, v[4:2], 3'b000, v[1:0], 3'b000};
   endfunction

   // 5-5-5 to 5-6-5: green low bit zero, bit 15 dropped
   function automatic logic [COLOR_W-1:0] color_16(input logic [15:0] v);
      color_16 = {v[14:10], v[9:5], 1'b0, v[4:0]};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pp2r_req_if.sv
`default_nettype none
interface pp2r_req_if;
   logic                       valid;
   logic                       ready;
   logic [pp2r_pkg::WORD_W-1:0] word_data;
   logic [pp2r_pkg::COL_W-1:0]  word_column;

   modport source (output valid, output word_data, output word_column, input ready);
   modport sink   (input valid, input word_data, input word_column, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pp2r_rsp_if.sv
`default_nettype none
interface pp2r_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pp2r_pkg::COLOR_W-1:0] pixel_color;
   logic [pp2r_pkg::PX_W-1:0]    pixel_x;
   logic                         last_of_word;
   logic                         line_end;

   modport source (output valid, output pixel_color, output pixel_x,
                   output last_of_word, output line_end, input ready);
   modport sink   (input valid, input pixel_color, input pixel_x,
                   input last_of_word, input line_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pp2r_lane.sv
`default_nettype none
// One pixel lane: picks its pixel out of the word, converts it and checks
// the window.
module pp2r_lane #(
   parameter int LANE = 0
) (
   input  wire logic [pp2r_pkg::WORD_W-1:0]  word_data,
   input  wire logic [pp2r_pkg::COL_W-1:0]   word_column,
   input  wire logic [pp2r_pkg::DEPTH_W-1:0] depth_mode,
   input  wire logic [pp2r_pkg::XW-1:0]      left,
   input  wire logic [pp2r_pkg::XW-1:0]      right,
   input  wire logic [pp2r_pkg::XW-1:0]      right_m1,
   output pp2r_pkg::lane_out_type            lane_out
);

   // lanes beyond the pixel count of a depth take a safe slice and stay off
   localparam bit USE8  = (LANE < 4);
   localparam bit USE16 = (LANE < 2);
   localparam int P8    = USE8  ? LANE : 0;
   localparam int P16   = USE16 ? LANE : 0;

   logic [pp2r_pkg::XW-1:0]      col_ext;
   logic [pp2r_pkg::XW-1:0]      x_full;
   logic                         used;
   logic                         in_win;
   logic [pp2r_pkg::COLOR_W-1:0] color;

   assign col_ext = pp2r_pkg::XW'(word_column);
   assign in_win  = (x_full >= left) && (x_full < right);

   always_comb begin
      x_full = '0;
      used   = 1'b0;
      color  = pp2r_pkg::COLOR_BLACK;
      case (depth_mode)
         pp2r_pkg::DEPTH_1BIT: begin
            used   = 1'b1;
            x_full = (col_ext << 5) | pp2r_pkg::XW'(LANE);
            color  = word_data[31-LANE] ? pp2r_pkg::COLOR_WHITE
                                        : pp2r_pkg::COLOR_BLACK;
         end
         pp2r_pkg::DEPTH_8BIT: begin
            used   = USE8;
            x_full = (col_ext << 2) | pp2r_pkg::XW'(P8);
            color  = pp2r_pkg::color_8(word_data[31-8*P8 -: 8]);
         end
         pp2r_pkg::DEPTH_16BIT: begin
            used   = USE16;
            x_full = (col_ext << 1) | pp2r_pkg::XW'(P16);
            color  = pp2r_pkg::color_16(word_data[31-16*P16 -: 16]);
         end
         default: begin
            used = 1'b0;
         end
      endcase
   end

   assign lane_out.color    = color;
   assign lane_out.hit      = used && in_win;
   assign lane_out.x        = x_full[pp2r_pkg::PX_W-1:0];
   assign lane_out.line_end = (x_full == right_m1);

endmodule
`default_nettype wire

FILE: rtl/core/pp2r_emit.sv
`default_nettype none
// Merge stage: holds the lane results of one word and sends the hits out
// left to right, one pixel per cycle while rsp is ready, through an output register.
module pp2r_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   output logic                      load_ready,
   input  pp2r_pkg::lane_out_type    lanes [pp2r_pkg::LANES],
   pp2r_rsp_if.source                rsp
);

   logic [pp2r_pkg::LANES-1:0]   mask_ff, mask_in;
   logic [pp2r_pkg::COLOR_W-1:0] color_ff [pp2r_pkg::LANES];
   logic [pp2r_pkg::PX_W-1:0]    x_ff     [pp2r_pkg::LANES];
   logic [pp2r_pkg::LANES-1:0]   end_ff;

   logic                         out_valid_ff, out_valid_in;
   logic [pp2r_pkg::COLOR_W-1:0] out_color_ff;
   logic [pp2r_pkg::PX_W-1:0]    out_x_ff;
   logic                         out_last_ff;
   logic                         out_end_ff;

   logic [pp2r_pkg::LANE_W-1:0]  pick;
   logic [pp2r_pkg::LANES-1:0]   rest;
   logic                         busy;
   logic                         out_free;
   logic                         fire;

   // lowest set lane is the leftmost pending pixel
   always_comb begin
      pick = '0;
      for (int i = pp2r_pkg::LANES - 1; i >= 0; i--) begin
         if (mask_ff[i]) pick = pp2r_pkg::LANE_W'(i);
      end
   end

   assign rest       = mask_ff & (mask_ff - pp2r_pkg::LANES'(1));
   assign busy       = |mask_ff;
   assign out_free   = !out_valid_ff || rsp.ready;
   assign fire       = busy && out_free;
   assign load_ready = !busy || (fire && (rest == '0));

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         for (int i = 0; i < pp2r_pkg::LANES; i++) mask_in[i] = lanes[i].hit;
      end else if (fire) begin
         mask_in = rest;
      end
      out_valid_in = fire ? 1'b1 : (out_valid_ff && !rsp.ready);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // word buffer and output payload
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < pp2r_pkg::LANES; i++) begin
            color_ff[i] <= lanes[i].color;
            x_ff[i]     <= lanes[i].x;
            end_ff[i]   <= lanes[i].line_end;
         end
      end
      if (fire) begin
         out_color_ff <= color_ff[pick];
         out_x_ff     <= x_ff[pick];
         out_end_ff   <= end_ff[pick];
         out_last_ff  <= (rest == '0);
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.pixel_color  = out_color_ff;
   assign rsp.pixel_x      = out_x_ff;
   assign rsp.last_of_word = out_last_ff;
   assign rsp.line_end     = out_end_ff;

endmodule
`default_nettype wire

FILE: rtl/core/packed_pixel_to_rgb565.sv
`default_nettype none
// Channel  Dir  Payload                                        Handshake
// req      in   word_data[31:0], word_column[9:0]              valid/ready
// rsp      out  pixel_color[15:0], pixel_x[10:0],              valid/ready
//               last_of_word, line_end
// csr      in   csr_index[1:0], csr_wdata[11:0]                csr_we
//
// One pixel leaves per cycle while rsp is ready; a word gives as many pixels as
// it has inside the window (none to 32; up to 2 at 16 bit, up to 4 at 8 bit).
// The single output register of the merge stage sets this rate. The first
// pixel of a word passes the word buffer and then the output register before
// it is valid. Reset is synchronous and clears the registers to their defaults
// and empties the pipeline.
// A stalled rsp holds the output; the next word is taken as the current
// one hands out its last pixel.
module packed_pixel_to_rgb565 #(
   parameter int MAX_LINE_PIXELS = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pp2r_req_if.sink                               req,
   pp2r_rsp_if.source                             rsp,
   input  wire logic                              csr_we,
   input  wire logic [pp2r_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pp2r_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [pp2r_pkg::DEPTH_W-1:0] depth_ff;
   logic [pp2r_pkg::LEFT_W-1:0]  left_ff;
   logic [pp2r_pkg::RIGHT_W-1:0] right_ff;

   logic [pp2r_pkg::XW-1:0] left_ext;
   logic [pp2r_pkg::XW-1:0] right_ext;
   logic [pp2r_pkg::XW-1:0] right_cl;
   logic [pp2r_pkg::XW-1:0] right_m1;

   pp2r_pkg::lane_out_type  lanes [pp2r_pkg::LANES];
   logic                    load_ready;
   logic                    load;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= pp2r_pkg::DEPTH_16BIT;
         left_ff  <= '0;
         right_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pp2r_pkg::CSR_DEPTH_MODE:   depth_ff <= csr_wdata[pp2r_pkg::DEPTH_W-1:0];
            pp2r_pkg::CSR_WINDOW_LEFT:  left_ff  <= csr_wdata[pp2r_pkg::LEFT_W-1:0];
            pp2r_pkg::CSR_WINDOW_RIGHT: right_ff <= csr_wdata[pp2r_pkg::RIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // right edge clamped to the line length
   assign left_ext  = pp2r_pkg::XW'(left_ff);
   assign right_ext = pp2r_pkg::XW'(right_ff);
   assign right_cl  = (right_ext > pp2r_pkg::XW'(MAX_LINE_PIXELS))
                    ? pp2r_pkg::XW'(MAX_LINE_PIXELS) : right_ext;
   assign right_m1  = right_cl - pp2r_pkg::XW'(1);

   // pixel lanes
   for (genvar g = 0; g < pp2r_pkg::LANES; g++) begin : g_lane
      pp2r_lane #(.LANE(g)) u_lane (
         .word_data   (req.word_data),
         .word_column (req.word_column),
         .depth_mode  (depth_ff),
         .left        (left_ext),
         .right       (right_cl),
         .right_m1    (right_m1),
         .lane_out    (lanes[g])
      );
   end

   assign req.ready = load_ready;
   assign load      = req.valid && load_ready;

   pp2r_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_ready (load_ready),
      .lanes      (lanes),
      .rsp        (rsp)
   );

endmodule
`default_nettype wire
